FILE: rtl/qida_pkg.sv
// shared types and codes for the queue identifier allocator
// no dependencies; used by qida_cell, the top level and the checker
package qida_pkg;

    // default sizing
    localparam int QUEUE_COUNT_DEF  = 64;
    localparam int DEVICE_COUNT_DEF = 1;
    localparam int REF_MAX_DEF      = 255;

    // request op codes
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_DROP  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_DEV    = 3'd1;
    localparam logic [2:0] ST_BAD_ID     = 3'd2;
    localparam logic [2:0] ST_NONE_FREE  = 3'd3;
    localparam logic [2:0] ST_REFERENCED = 3'd4;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW   = 3'd6;
    localparam logic [2:0] ST_NOT_ALLOC  = 3'd7;

    // command seen by the cell that owns the identifier
    localparam logic [2:0] CMD_NOP   = 3'd0;
    localparam logic [2:0] CMD_MARK  = 3'd1;
    localparam logic [2:0] CMD_FREE  = 3'd2;
    localparam logic [2:0] CMD_ADD   = 3'd3;
    localparam logic [2:0] CMD_DROP  = 3'd4;
    localparam logic [2:0] CMD_QUERY = 3'd5;

    // token walking the cell chain
    typedef struct packed {
        logic       valid;
        logic [2:0] status;
        logic       refd;
    } qida_link_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic [2:0] cmd;
        logic       room;
        logic       push;
        logic       pop;
    } qida_ctrl_t;

endpackage

FILE: rtl/qida_cell.sv
// one cell of the allocator chain: a free list slot plus the reference
// count and allocated flag of its own identifier; depends on qida_pkg
module qida_cell
    import qida_pkg::*;
#(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
    parameter int REF_MAX     = REF_MAX_DEF,
    parameter int IDX         = 0
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  qida_ctrl_t                     ctrl,
    input  logic [$clog2(QUEUE_COUNT)-1:0] qid,
    input  qida_link_t                     link_in,
    output qida_link_t                     link_out,
    input  logic [$clog2(QUEUE_COUNT)-1:0] slot_prev,
    input  logic [$clog2(QUEUE_COUNT)-1:0] slot_next,
    output logic [$clog2(QUEUE_COUNT)-1:0] slot
);

    localparam int ID_W  = $clog2(QUEUE_COUNT);
    localparam int REF_W = $clog2(REF_MAX + 1);

    logic [ID_W-1:0]  slot_reg;
    logic [ID_W-1:0]  slot_next_val;
    logic [REF_W-1:0] ref_reg;
    logic [REF_W-1:0] ref_next;
    logic             alloc_reg;
    logic             alloc_next;
    qida_link_t       link_reg;
    qida_link_t       link_next;
    logic             match;

    assign match = link_in.valid && (qid == ID_W'(IDX));

    // free list shift: push moves away from the head, pop toward it
    always_comb
    begin
        slot_next_val = slot_reg;
        if (ctrl.push)
        begin
            slot_next_val = slot_prev;
        end
        else if (ctrl.pop)
        begin
            slot_next_val = slot_next;
        end
    end

    always_comb
    begin
        ref_next   = ref_reg;
        alloc_next = alloc_reg;
        link_next  = link_in;
        if (match)
        begin
            case (ctrl.cmd)
                CMD_MARK:
                begin
                    alloc_next = 1'b1;
                end
                CMD_FREE:
                begin
                    if (ref_reg != '0)
                    begin
                        link_next.status = ST_REFERENCED;
                    end
                    else if (!alloc_reg || !ctrl.room)
                    begin
                        link_next.status = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        alloc_next = 1'b0;
                    end
                end
                CMD_ADD:
                begin
                    if (ref_reg >= REF_W'(REF_MAX))
                    begin
                        link_next.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        ref_next = ref_reg + 1'b1;
                    end
                end
                CMD_DROP:
                begin
                    if (ref_reg == '0)
                    begin
                        link_next.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ref_next = ref_reg - 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    link_next.refd = (ref_reg != '0);
                end
                default:
                begin
                    link_next = link_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= ID_W'(IDX);
            ref_reg   <= '0;
            alloc_reg <= 1'b0;
            link_reg  <= '0;
        end
        else
        begin
            slot_reg  <= slot_next_val;
            ref_reg   <= ref_next;
            alloc_reg <= alloc_next;
            link_reg  <= link_next;
        end
    end

    assign slot     = slot_reg;
    assign link_out = link_reg;

endmodule

FILE: rtl/queue_id_allocator_with_refcount_unit.sv
// top level of the queue identifier allocator with reference counts
// depends on qida_pkg and qida_cell
//
//  port group | dir | payload (low bit first)
//  -----------+-----+------------------------------------------------
//  s_axis_*   | in  | op[2:0], dev_id[4:3], queue_id[10:5], zero pad
//  m_axis_*   | out | status[2:0], granted_id[8:3], referenced[9],
//             |     | free_left[16:10], zero pad
//
//  one request at a time; a token walks the chain one cell per cycle
//  reset loads the free list with 0 at the head, clears all reference counts and allocated flags
//  a stalled result holds in the output register; a finished request waits
//  for that register before the next request is taken
module queue_id_allocator_with_refcount_unit
    import qida_pkg::*;
#(
    parameter int QUEUE_COUNT  = QUEUE_COUNT_DEF,
    parameter int DEVICE_COUNT = DEVICE_COUNT_DEF,
    parameter int REF_MAX      = REF_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op, dev_id, queue_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, granted_id, referenced, free_left
);

    localparam int ID_W  = $clog2(QUEUE_COUNT);
    localparam int CNT_W = $clog2(QUEUE_COUNT + 1);

    // control states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg,  state_next;
    logic [2:0]       cmd_reg,    cmd_next;
    logic [ID_W-1:0]  qid_reg,    qid_next;
    logic             start_reg,  start_next;
    logic [2:0]       early_reg,  early_next;
    logic [ID_W-1:0]  grant_reg,  grant_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [2:0]       res_st_reg, res_st_next;
    logic             res_rf_reg, res_rf_next;
    logic             mval_reg,   mval_next;
    logic [2:0]       o_st_reg,   o_st_next;
    logic [ID_W-1:0]  o_gr_reg,   o_gr_next;
    logic             o_rf_reg,   o_rf_next;
    logic [CNT_W-1:0] o_left_reg, o_left_next;

    // request fields
    logic [2:0]      in_op;
    logic [1:0]      in_dev;
    logic [5:0]      in_qid;
    logic            accept;

    qida_ctrl_t      ctrl;
    qida_link_t      links [QUEUE_COUNT+1];
    logic [ID_W-1:0] slots [QUEUE_COUNT];
    qida_link_t      tail;

    assign in_op  = s_axis_tdata[2:0];
    assign in_dev = s_axis_tdata[4:3];
    assign in_qid = s_axis_tdata[10:5];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign tail          = links[QUEUE_COUNT];

    // token enters cell 0 the cycle after accept
    assign links[0] = '{valid: start_reg, status: early_reg, refd: 1'b0};

    // cell chain
    for (genvar g = 0; g < QUEUE_COUNT; g++)
    begin : g_cell
        logic [ID_W-1:0] prev_slot;
        logic [ID_W-1:0] next_slot;

        if (g == 0)
        begin : g_head
            assign prev_slot = qid_reg;
        end
        else
        begin : g_body
            assign prev_slot = slots[g-1];
        end

        if (g == QUEUE_COUNT - 1)
        begin : g_last
            assign next_slot = slots[g];
        end
        else
        begin : g_more
            assign next_slot = slots[g+1];
        end

        qida_cell #(
            .QUEUE_COUNT (QUEUE_COUNT),
            .REF_MAX     (REF_MAX),
            .IDX         (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .qid       (qid_reg),
            .link_in   (links[g]),
            .link_out  (links[g+1]),
            .slot_prev (prev_slot),
            .slot_next (next_slot),
            .slot      (slots[g])
        );
    end

    // request decode, pop on an accepted alloc with identifiers left, push when a free comes back clean
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        qid_next    = qid_reg;
        start_next  = 1'b0;
        early_next  = early_reg;
        grant_next  = grant_reg;
        count_next  = count_reg;
        res_st_next = res_st_reg;
        res_rf_next = res_rf_reg;
        mval_next   = mval_reg;
        o_st_next   = o_st_reg;
        o_gr_next   = o_gr_reg;
        o_rf_next   = o_rf_reg;
        o_left_next = o_left_reg;

        ctrl.cmd  = cmd_reg;
        ctrl.room = (count_reg != CNT_W'(QUEUE_COUNT));
        ctrl.push = 1'b0;
        ctrl.pop  = 1'b0;

        // output register drains
        if (mval_reg && m_axis_tready)
        begin
            mval_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    start_next = 1'b1;
                    early_next = ST_OK;
                    cmd_next   = CMD_NOP;
                    grant_next = '0;
                    qid_next   = ID_W'(in_qid);
                    if (int'(in_dev) >= DEVICE_COUNT)
                    begin
                        early_next = ST_BAD_DEV;
                    end
                    else if (in_op == OP_ALLOC)
                    begin
                        if (count_reg == '0)
                        begin
                            early_next = ST_NONE_FREE;
                        end
                        else
                        begin
                            // head leaves the list; its cell gets marked
                            ctrl.pop   = 1'b1;
                            count_next = count_reg - 1'b1;
                            grant_next = slots[0];
                            qid_next   = slots[0];
                            cmd_next   = CMD_MARK;
                        end
                    end
                    else if (in_op == OP_FREE || in_op == OP_ADD ||
                             in_op == OP_DROP || in_op == OP_QUERY)
                    begin
                        if (int'(in_qid) >= QUEUE_COUNT)
                        begin
                            early_next = ST_BAD_ID;
                        end
                        else
                        begin
                            case (in_op)
                                OP_FREE:  cmd_next = CMD_FREE;
                                OP_ADD:   cmd_next = CMD_ADD;
                                OP_DROP:  cmd_next = CMD_DROP;
                                OP_QUERY: cmd_next = CMD_QUERY;
                                default:  cmd_next = CMD_NOP;
                            endcase
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    res_st_next = tail.status;
                    res_rf_next = tail.refd;
                    state_next  = S_DONE;
                    // identifier goes back on the head of the list
                    if (cmd_reg == CMD_FREE && tail.status == ST_OK)
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!mval_reg || m_axis_tready)
                begin
                    mval_next   = 1'b1;
                    o_st_next   = res_st_reg;
                    o_gr_next   = grant_reg;
                    o_rf_next   = res_rf_reg;
                    o_left_next = count_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
            count_reg <= CNT_W'(QUEUE_COUNT);
            mval_reg  <= 1'b0;
            cmd_reg   <= CMD_NOP;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
            mval_reg  <= mval_next;
            cmd_reg   <= cmd_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        qid_reg    <= qid_next;
        early_reg  <= early_next;
        grant_reg  <= grant_next;
        res_st_reg <= res_st_next;
        res_rf_reg <= res_rf_next;
        o_st_reg   <= o_st_next;
        o_gr_reg   <= o_gr_next;
        o_rf_reg   <= o_rf_next;
        o_left_reg <= o_left_next;
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {7'd0, 7'(o_left_reg), o_rf_reg, 6'(o_gr_reg), o_st_reg};

endmodule

FILE: rtl/qida_checker.sv
// port-level checks for the queue identifier allocator, bound to the top
// depends on qida_pkg
module qida_checker
    import qida_pkg::*;
#(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // stalled result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // waiting request keeps its payload
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |=> (s_axis_tvalid && $stable(s_axis_tdata)))
        else $error("request changed while waiting");

    // free count never above the pool size
    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[16:10]) <= QUEUE_COUNT))
        else $error("free count above pool size");

    // granted identifier and referenced flag come only with success
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[8:3] != 6'd0 || m_axis_tdata[9])) |->
        (m_axis_tdata[2:0] == ST_OK))
        else $error("granted id or referenced flag with error status");

    // empty list reported only with nothing left
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] == ST_NONE_FREE) |->
        (m_axis_tdata[16:10] == 7'd0))
        else $error("none free with identifiers left");

endmodule

bind queue_id_allocator_with_refcount_unit qida_checker #(
    .QUEUE_COUNT (QUEUE_COUNT)
) u_qida_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
